[hdl/calendar_datetime_stepper_unit_defines.svh]
// assertion macros for the calendar date-time stepper
// used by calendar_datetime_stepper_unit.sv, no other dependencies
`ifndef CALENDAR_DATETIME_STEPPER_UNIT_DEFINES_SVH
`define CALENDAR_DATETIME_STEPPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CDSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("calendar stepper check failed");
`define CDSU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("calendar stepper forbidden condition");
`else
`define CDSU_ASSERT(lbl, clk, rstn, prop)
`define CDSU_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hdl/cdsu_pkg.sv]
// types, constants and helper functions for the calendar date-time stepper
// no dependencies; used by cdsu_step and calendar_datetime_stepper_unit
package cdsu_pkg;

  typedef enum logic [2:0] {
    OpLoad     = 3'd0,
    OpNextHour = 3'd1,
    OpPrevHour = 3'd2,
    OpNextDay  = 3'd3,
    OpPrevDay  = 3'd4,
    OpRead     = 3'd5
  } op_e;

  // yr_mod tracks year mod 100 so the date word needs no divider
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  yr_mod;
  } dt_t;

  localparam logic [11:0] YearLoadMin   = 12'd2000;
  localparam logic [11:0] YearLoadMax   = 12'd2099;
  localparam logic [11:0] YearTop       = 12'hFFF;
  localparam logic [3:0]  MonthMax      = 4'd12;
  localparam logic [3:0]  MonthFeb      = 4'd2;
  localparam logic [4:0]  HourMax       = 5'd23;
  localparam logic [5:0]  MinSecMax     = 6'd59;
  localparam logic [4:0]  LeapFebDays   = 5'd29;
  localparam logic [6:0]  YrModMax      = 7'd99;
  localparam logic [6:0]  YrModOfTop    = 7'd95;
  localparam logic [7:0]  DateFill      = 8'h20;

  localparam dt_t DtReset = '{
    year: 12'd2000, month: 4'd1, day: 5'd1, hour: 5'd0,
    minute: 6'd0, second: 6'd0, yr_mod: 7'd0
  };

  function automatic logic [4:0] month_len(input logic [11:0] year,
                                           input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MonthFeb: len = (year[1:0] == 2'b00) ? LeapFebDays : 5'd28;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

  // binary 0..99 to two bcd digits, tens found by independent compares
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(i * 10)) begin
        tens = 4'(i);
      end
    end
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

[hdl/cdsu_step.sv]
// next-state logic: load check and hour/day stepping with carries
// depends on cdsu_pkg
module cdsu_step (
  input  cdsu_pkg::dt_t cur_i,
  input  cdsu_pkg::dt_t load_i,
  input  cdsu_pkg::op_e op_i,
  output cdsu_pkg::dt_t nxt_o,
  output logic          ok_o
);

  function automatic cdsu_pkg::dt_t day_fwd(input cdsu_pkg::dt_t d);
    cdsu_pkg::dt_t r;
    r = d;
    if (d.day >= cdsu_pkg::month_len(d.year, d.month)) begin
      r.day = 5'd1;
      if (d.month >= cdsu_pkg::MonthMax) begin
        r.month = 4'd1;
        r.year  = d.year + 12'd1;
        if (d.year == cdsu_pkg::YearTop || d.yr_mod >= cdsu_pkg::YrModMax) begin
          r.yr_mod = 7'd0;
        end else begin
          r.yr_mod = d.yr_mod + 7'd1;
        end
      end else begin
        r.month = d.month + 4'd1;
      end
    end else begin
      r.day = d.day + 5'd1;
    end
    return r;
  endfunction

  function automatic cdsu_pkg::dt_t day_bwd(input cdsu_pkg::dt_t d);
    cdsu_pkg::dt_t r;
    r = d;
    if (d.day <= 5'd1) begin
      if (d.month <= 4'd1 || d.month > cdsu_pkg::MonthMax) begin
        r.month = cdsu_pkg::MonthMax;
        r.year  = d.year - 12'd1;
        if (d.year == 12'd0) begin
          r.yr_mod = cdsu_pkg::YrModOfTop;
        end else if (d.yr_mod == 7'd0) begin
          r.yr_mod = cdsu_pkg::YrModMax;
        end else begin
          r.yr_mod = d.yr_mod - 7'd1;
        end
      end else begin
        r.month = d.month - 4'd1;
      end
      r.day = cdsu_pkg::month_len(r.year, r.month);
    end else begin
      r.day = d.day - 5'd1;
    end
    return r;
  endfunction

  logic          load_ok;
  cdsu_pkg::dt_t hour_up;
  cdsu_pkg::dt_t hour_dn;

  assign load_ok = load_i.second <= cdsu_pkg::MinSecMax &&
                   load_i.minute <= cdsu_pkg::MinSecMax &&
                   load_i.hour <= cdsu_pkg::HourMax &&
                   load_i.day >= 5'd1 &&
                   load_i.month >= 4'd1 && load_i.month <= cdsu_pkg::MonthMax &&
                   load_i.year >= cdsu_pkg::YearLoadMin &&
                   load_i.year <= cdsu_pkg::YearLoadMax &&
                   load_i.day <= cdsu_pkg::month_len(load_i.year, load_i.month);

  always_comb begin
    hour_up = cur_i;
    if (cur_i.hour >= cdsu_pkg::HourMax) begin
      hour_up      = day_fwd(cur_i);
      hour_up.hour = 5'd0;
    end else begin
      hour_up.hour = cur_i.hour + 5'd1;
    end
  end

  always_comb begin
    hour_dn = cur_i;
    if (cur_i.hour == 5'd0) begin
      hour_dn      = day_bwd(cur_i);
      hour_dn.hour = cdsu_pkg::HourMax;
    end else begin
      hour_dn.hour = cur_i.hour - 5'd1;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    ok_o  = 1'b1;
    case (op_i)
      cdsu_pkg::OpLoad: begin
        ok_o = load_ok;
        if (load_ok) begin
          nxt_o = load_i;
        end
      end
      cdsu_pkg::OpNextHour: nxt_o = hour_up;
      cdsu_pkg::OpPrevHour: nxt_o = hour_dn;
      cdsu_pkg::OpNextDay:  nxt_o = day_fwd(cur_i);
      cdsu_pkg::OpPrevDay:  nxt_o = day_bwd(cur_i);
      default:              nxt_o = cur_i;
    endcase
  end

endmodule

[hdl/calendar_datetime_stepper_unit.sv]
// top level of the calendar date-time stepper with bcd time and date words
// depends on cdsu_pkg, cdsu_step and calendar_datetime_stepper_unit_defines.svh
//
//  channel  handshake                 payload
//  -------  ------------------------  ----------------------------------------
//  in       in_valid_i / in_ready_o   opcode_i, in_year_i .. in_second_i
//  out      out_valid_o / out_ready_i out_year_o .. out_second_o, accepted_o,
//                                     time_word_o, date_word_o
//
// one request per cycle while the output is not stalled; its result shows in the cycle after acceptance
// the stored date-time doubles as the result register, so a request is taken
// whenever the result slot is empty or being drained in the same cycle
// reset leaves 2000-01-01 00:00:00 stored and the result slot empty
// a stalled output holds its result and stalls the input side
`include "calendar_datetime_stepper_unit_defines.svh"

module calendar_datetime_stepper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [11:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [4:0]  in_hour_i,
  input  logic [5:0]  in_minute_i,
  input  logic [5:0]  in_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o,
  output logic        accepted_o,
  output logic [21:0] time_word_o,
  output logic [29:0] date_word_o
);

  cdsu_pkg::dt_t cur_q, cur_d;
  cdsu_pkg::dt_t load_req;
  logic          out_valid_q, out_valid_d;
  logic          accepted_q;
  logic [21:0]   time_word_q, time_word_d;
  logic [29:0]   date_word_q, date_word_d;
  logic          fire;
  logic          step_ok;
  logic [11:0]   load_yr_off;
  logic [7:0]    bcd_hour, bcd_min, bcd_sec, bcd_day, bcd_month, bcd_yr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // a valid load year lies in 2000..2099, so the offset is the year mod 100
  assign load_yr_off = in_year_i - cdsu_pkg::YearLoadMin;

  always_comb begin
    load_req.year   = in_year_i;
    load_req.month  = in_month_i;
    load_req.day    = in_day_i;
    load_req.hour   = in_hour_i;
    load_req.minute = in_minute_i;
    load_req.second = in_second_i;
    load_req.yr_mod = load_yr_off[6:0];
  end

  cdsu_step u_step (
    .cur_i  (cur_q),
    .load_i (load_req),
    .op_i   (cdsu_pkg::op_e'(opcode_i)),
    .nxt_o  (cur_d),
    .ok_o   (step_ok)
  );

  always_comb begin
    bcd_hour  = cdsu_pkg::to_bcd({2'b00, cur_d.hour});
    bcd_min   = cdsu_pkg::to_bcd({1'b0, cur_d.minute});
    bcd_sec   = cdsu_pkg::to_bcd({1'b0, cur_d.second});
    bcd_day   = cdsu_pkg::to_bcd({2'b00, cur_d.day});
    bcd_month = cdsu_pkg::to_bcd({3'b000, cur_d.month});
    bcd_yr    = cdsu_pkg::to_bcd(cur_d.yr_mod);
    time_word_d = {bcd_hour[5:0], bcd_min, bcd_sec};
    date_word_d = {bcd_day[5:0], bcd_month | cdsu_pkg::DateFill, bcd_yr,
                   cdsu_pkg::DateFill};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_q       <= cdsu_pkg::DtReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        cur_q <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      accepted_q  <= step_ok;
      time_word_q <= time_word_d;
      date_word_q <= date_word_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_year_o   = cur_q.year;
  assign out_month_o  = cur_q.month;
  assign out_day_o    = cur_q.day;
  assign out_hour_o   = cur_q.hour;
  assign out_minute_o = cur_q.minute;
  assign out_second_o = cur_q.second;
  assign accepted_o   = accepted_q;
  assign time_word_o  = time_word_q;
  assign date_word_o  = date_word_q;

  `CDSU_ASSERT(a_month_range, clk_i, rst_ni, cur_q.month >= 4'd1 && cur_q.month <= cdsu_pkg::MonthMax)
  `CDSU_ASSERT(a_day_fits, clk_i, rst_ni, cur_q.day >= 5'd1 && cur_q.day <= cdsu_pkg::month_len(cur_q.year, cur_q.month))
  `CDSU_ASSERT_NEVER(a_hour_range, clk_i, rst_ni, cur_q.hour > cdsu_pkg::HourMax)
  `CDSU_ASSERT_NEVER(a_yr_mod_range, clk_i, rst_ni, cur_q.yr_mod > cdsu_pkg::YrModMax)
  `CDSU_ASSERT(a_reject_holds, clk_i, rst_ni, fire && !step_ok |=> cur_q == $past(cur_q))

endmodule
